[design/iadf_pkg.sv]
package iadf_pkg;

   localparam int HEADER_BYTES   = 12;
   localparam int PREAMBLE_BYTES = 8;
   localparam int CNT_W = ($clog2(HEADER_BYTES + 1) > $clog2(PREAMBLE_BYTES))
                          ? $clog2(HEADER_BYTES + 1) : $clog2(PREAMBLE_BYTES);

   localparam int BYTE_W  = 8;
   localparam int TAG_W   = 32;
   localparam int SHIFT_W = 64;
   localparam int SIZE_W  = 33;
   localparam int TOTAL_W = 40;
   localparam int STAMP_W = 48;
   localparam int SEC_W   = 32;
   localparam int TICK_W  = 17;
   localparam int PROD_W  = TOTAL_W + TICK_W;
   localparam int DIV_W   = PROD_W;
   localparam int DVR_W   = 18;
   localparam int STEP_W  = $clog2(DIV_W);

   localparam int BPS_W  = 6;
   localparam int CHN_W  = 4;
   localparam int RATE_W = 18;
   localparam int CAP_W  = 17;
   localparam int BC_W   = BPS_W + CHN_W;

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [BPS_W-1:0]  BPS_RESET  = BPS_W'(16);
   localparam logic [CHN_W-1:0]  CHN_RESET  = CHN_W'(1);
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(22050);
   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(4096);

   localparam logic [TAG_W-1:0]  TAG_AUDI      = 32'h4155_4449;
   localparam logic [TICK_W-1:0] TICKS_PER_SEC = 17'd90000;
   // whole seconds of a saturated stamp
   localparam logic [SEC_W-1:0]  SECONDS_MAX   = SEC_W'(64'hFFFF_FFFF_FFFF / 64'd90000);

   typedef enum logic [1:0] {
      REG_BITS     = 2'd0,
      REG_CHANNELS = 2'd1,
      REG_RATE     = 2'd2,
      REG_CAPACITY = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_PREAMBLE = 2'd1,
      PH_SKIP     = 2'd2,
      PH_PAYLOAD  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DIV_FRAMES  = 2'd0,
      DIV_STAMP   = 2'd1,
      DIV_SECONDS = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_STREAM,
      ST_FRAMES_GO,
      ST_FRAMES_WAIT,
      ST_TOTAL,
      ST_PRODUCT,
      ST_STAMP_GO,
      ST_STAMP_WAIT,
      ST_SECONDS_GO,
      ST_SECONDS_WAIT
   } ctrl_state_type;

   typedef struct packed {
      logic [BPS_W-1:0]  bits_per_sample;
      logic [CHN_W-1:0]  channel_count;
      logic [RATE_W-1:0] sample_rate;
      logic [CAP_W-1:0]  buffer_capacity;
   } cfg_type;

   typedef struct packed {
      logic        stream_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        total_load;
      logic        product_load;
      logic        stamp_load;
      logic        seconds_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic audi_start;
      logic div_busy;
   } ctrl_status_type;

endpackage

[design/iff_audio_chunk_deframer_unit.sv]
// payload byte transaction: result is registered, visible in the cycle after acceptance
// header, preamble, skipped and payload bytes are taken one per cycle when the output is free
// after the last preamble byte of an audio chunk the input stalls for the chunk arithmetic:
// three 57-step divisions (frames, stamp, seconds) in one shared bit-serial divider
// synchronous active-high reset clears all control state and loads the register defaults
module iff_audio_chunk_deframer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [iadf_pkg::BYTE_W-1:0]  req_stream_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [iadf_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic [iadf_pkg::STAMP_W-1:0] rsp_stamp,
   output logic [iadf_pkg::SEC_W-1:0]   rsp_stamp_seconds,
   output logic                         rsp_buffer_end,
   output logic                         rsp_chunk_end,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [iadf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [iadf_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [iadf_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   iadf_pkg::cfg_type         cfg;
   iadf_pkg::ctrl_cmd_type    cmd;
   iadf_pkg::ctrl_status_type status;

   iadf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   iadf_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   iadf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_stamp         (rsp_stamp),
      .rsp_stamp_seconds (rsp_stamp_seconds),
      .rsp_buffer_end    (rsp_buffer_end),
      .rsp_chunk_end     (rsp_chunk_end)
   );

endmodule

[design/iadf_csr.sv]
module iadf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [iadf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [iadf_pkg::DATA_W-1:0] csr_pwdata,
   output logic [iadf_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output iadf_pkg::cfg_type           cfg
);

   iadf_pkg::cfg_type     cfg_ff;
   iadf_pkg::cfg_type     cfg_in;
   iadf_pkg::reg_index_type index;
   logic                  write_en;

   assign index      = iadf_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            iadf_pkg::REG_BITS:
               cfg_in.bits_per_sample = csr_pwdata[iadf_pkg::BPS_W-1:0];
            iadf_pkg::REG_CHANNELS:
               cfg_in.channel_count = csr_pwdata[iadf_pkg::CHN_W-1:0];
            iadf_pkg::REG_RATE:
               cfg_in.sample_rate = csr_pwdata[iadf_pkg::RATE_W-1:0];
            iadf_pkg::REG_CAPACITY:
               cfg_in.buffer_capacity = csr_pwdata[iadf_pkg::CAP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         iadf_pkg::REG_BITS:     csr_prdata = iadf_pkg::DATA_W'(cfg_ff.bits_per_sample);
         iadf_pkg::REG_CHANNELS: csr_prdata = iadf_pkg::DATA_W'(cfg_ff.channel_count);
         iadf_pkg::REG_RATE:     csr_prdata = iadf_pkg::DATA_W'(cfg_ff.sample_rate);
         iadf_pkg::REG_CAPACITY: csr_prdata = iadf_pkg::DATA_W'(cfg_ff.buffer_capacity);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bits_per_sample <= iadf_pkg::BPS_RESET;
         cfg_ff.channel_count   <= iadf_pkg::CHN_RESET;
         cfg_ff.sample_rate     <= iadf_pkg::RATE_RESET;
         cfg_ff.buffer_capacity <= iadf_pkg::CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/iadf_divider.sv]
module iadf_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [iadf_pkg::DIV_W-1:0] dividend,
   input  logic [iadf_pkg::DVR_W-1:0] divisor,
   output logic                       busy,
   output logic [iadf_pkg::DIV_W-1:0] quotient
);

   logic                        busy_ff, busy_in;
   logic [iadf_pkg::STEP_W-1:0] step_ff, step_in;
   logic [iadf_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [iadf_pkg::DVR_W-1:0]  rem_ff, rem_in;
   logic [iadf_pkg::DVR_W-1:0]  dvr_ff, dvr_in;
   logic [iadf_pkg::DVR_W:0]    rem_shift;
   logic [iadf_pkg::DVR_W:0]    rem_diff;
   logic                        fits;

   // restoring division, one quotient bit per cycle, msb first
   assign rem_shift = {rem_ff, quo_ff[iadf_pkg::DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvr_ff};
   assign fits      = rem_shift >= {1'b0, dvr_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = iadf_pkg::STEP_W'(iadf_pkg::DIV_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[iadf_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? rem_diff[iadf_pkg::DVR_W-1:0] : rem_shift[iadf_pkg::DVR_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[design/iadf_controller.sv]
module iadf_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  iadf_pkg::ctrl_status_type status,
   output iadf_pkg::ctrl_cmd_type    cmd
);

   iadf_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iadf_pkg::ST_STREAM:
            if (status.audi_start) begin
               state_in = iadf_pkg::ST_FRAMES_GO;
            end
         iadf_pkg::ST_FRAMES_GO:  state_in = iadf_pkg::ST_FRAMES_WAIT;
         iadf_pkg::ST_FRAMES_WAIT:
            if (!status.div_busy) begin
               state_in = iadf_pkg::ST_TOTAL;
            end
         iadf_pkg::ST_TOTAL:      state_in = iadf_pkg::ST_PRODUCT;
         iadf_pkg::ST_PRODUCT:    state_in = iadf_pkg::ST_STAMP_GO;
         iadf_pkg::ST_STAMP_GO:   state_in = iadf_pkg::ST_STAMP_WAIT;
         iadf_pkg::ST_STAMP_WAIT:
            if (!status.div_busy) begin
               state_in = iadf_pkg::ST_SECONDS_GO;
            end
         iadf_pkg::ST_SECONDS_GO: state_in = iadf_pkg::ST_SECONDS_WAIT;
         iadf_pkg::ST_SECONDS_WAIT:
            if (!status.div_busy) begin
               state_in = iadf_pkg::ST_STREAM;
            end
         default:                 state_in = iadf_pkg::ST_STREAM;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.div_sel      = iadf_pkg::DIV_FRAMES;
      unique case (state_ff)
         iadf_pkg::ST_STREAM:       cmd.stream_en = 1'b1;
         iadf_pkg::ST_FRAMES_GO:    cmd.div_start = 1'b1;
         iadf_pkg::ST_FRAMES_WAIT:  cmd.div_sel   = iadf_pkg::DIV_FRAMES;
         iadf_pkg::ST_TOTAL:        cmd.total_load   = 1'b1;
         iadf_pkg::ST_PRODUCT:      cmd.product_load = 1'b1;
         iadf_pkg::ST_STAMP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = iadf_pkg::DIV_STAMP;
         end
         iadf_pkg::ST_STAMP_WAIT:   cmd.stamp_load = !status.div_busy;
         iadf_pkg::ST_SECONDS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = iadf_pkg::DIV_SECONDS;
         end
         iadf_pkg::ST_SECONDS_WAIT: cmd.seconds_load = !status.div_busy;
         default:                   cmd.stream_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iadf_pkg::ST_STREAM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/iadf_datapath.sv]
module iadf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  iadf_pkg::cfg_type            cfg,
   input  iadf_pkg::ctrl_cmd_type       cmd,
   output iadf_pkg::ctrl_status_type    status,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [iadf_pkg::BYTE_W-1:0]  req_stream_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [iadf_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic [iadf_pkg::STAMP_W-1:0] rsp_stamp,
   output logic [iadf_pkg::SEC_W-1:0]   rsp_stamp_seconds,
   output logic                         rsp_buffer_end,
   output logic                         rsp_chunk_end
);

   iadf_pkg::phase_type            phase_ff, phase_in;
   logic [iadf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [iadf_pkg::SHIFT_W-1:0]   preamble_ff, preamble_in;
   logic [iadf_pkg::SIZE_W-1:0]    left_ff, left_in;
   logic [iadf_pkg::CAP_W-1:0]     fill_ff, fill_in;
   logic [iadf_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [iadf_pkg::PROD_W-1:0]    product_ff;
   logic [iadf_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [iadf_pkg::SEC_W-1:0]     seconds_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [iadf_pkg::BYTE_W-1:0]    rsp_byte_ff;
   logic [iadf_pkg::STAMP_W-1:0]   rsp_stamp_ff;
   logic [iadf_pkg::SEC_W-1:0]     rsp_seconds_ff;
   logic                           rsp_bend_ff, rsp_cend_ff;

   logic                           accept;
   logic                           out_load;
   logic                           bend, cend;
   logic                           last_preamble;
   logic [iadf_pkg::SHIFT_W-1:0]   shift_next;
   logic [iadf_pkg::TAG_W-1:0]     tag;
   logic [iadf_pkg::SIZE_W-1:0]    size_sum, size;
   logic [iadf_pkg::CAP_W-1:0]     cap, fill_next;
   logic [iadf_pkg::BPS_W-1:0]     bits_eff;
   logic [iadf_pkg::CHN_W-1:0]     chans_eff;
   logic [iadf_pkg::RATE_W-1:0]    rate_eff;
   logic [iadf_pkg::BC_W-1:0]      bits_chans;
   logic [iadf_pkg::DIV_W-1:0]     div_dividend, quotient;
   logic [iadf_pkg::DVR_W-1:0]     div_divisor;
   logic                           div_busy;
   logic [iadf_pkg::TOTAL_W:0]     total_sum;
   logic [iadf_pkg::PROD_W-1:0]    product;

   assign accept    = req_valid && req_ready;
   assign req_ready = cmd.stream_en && (!rsp_valid_ff || rsp_ready);

   assign shift_next = {preamble_ff[iadf_pkg::SHIFT_W-iadf_pkg::BYTE_W-1:0], req_stream_byte};
   assign tag        = shift_next[iadf_pkg::SHIFT_W-1:iadf_pkg::TAG_W];
   // round up to even, all ones rounds to 2^32
   assign size_sum   = {1'b0, shift_next[iadf_pkg::TAG_W-1:0]} + iadf_pkg::SIZE_W'(1);
   assign size       = {size_sum[iadf_pkg::SIZE_W-1:1], 1'b0};
   assign last_preamble = count_ff == iadf_pkg::CNT_W'(iadf_pkg::PREAMBLE_BYTES - 1);

   assign cap       = (cfg.buffer_capacity == '0) ? iadf_pkg::CAP_W'(1) : cfg.buffer_capacity;
   assign fill_next = fill_ff + 1'b1;

   assign status.audi_start = accept && (phase_ff == iadf_pkg::PH_PREAMBLE) && last_preamble
                              && (tag == iadf_pkg::TAG_AUDI);
   assign status.div_busy   = div_busy;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      preamble_in = preamble_ff;
      left_in     = left_ff;
      fill_in     = fill_ff;
      out_load    = 1'b0;
      cend        = 1'b0;
      bend        = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            iadf_pkg::PH_HEADER: begin
               if (count_ff == iadf_pkg::CNT_W'(iadf_pkg::HEADER_BYTES - 1)) begin
                  phase_in = iadf_pkg::PH_PREAMBLE;
                  count_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            iadf_pkg::PH_PREAMBLE: begin
               preamble_in = shift_next;
               if (last_preamble) begin
                  count_in = '0;
                  left_in  = size;
                  if (tag == iadf_pkg::TAG_AUDI) begin
                     fill_in  = '0;
                     phase_in = (size != '0) ? iadf_pkg::PH_PAYLOAD : iadf_pkg::PH_PREAMBLE;
                  end else begin
                     phase_in = (size != '0) ? iadf_pkg::PH_SKIP : iadf_pkg::PH_PREAMBLE;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            iadf_pkg::PH_SKIP: begin
               left_in = left_ff - 1'b1;
               if (left_ff == iadf_pkg::SIZE_W'(1)) begin
                  phase_in = iadf_pkg::PH_PREAMBLE;
               end
            end
            iadf_pkg::PH_PAYLOAD: begin
               left_in  = left_ff - 1'b1;
               cend     = left_ff == iadf_pkg::SIZE_W'(1);
               bend     = cend || (fill_next >= cap);
               fill_in  = bend ? '0 : fill_next;
               out_load = 1'b1;
               if (cend) begin
                  phase_in = iadf_pkg::PH_PREAMBLE;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // chunk arithmetic, run by the controller after an audio preamble
   assign bits_eff   = (cfg.bits_per_sample == '0) ? iadf_pkg::BPS_W'(1) : cfg.bits_per_sample;
   assign chans_eff  = (cfg.channel_count == '0) ? iadf_pkg::CHN_W'(1) : cfg.channel_count;
   assign rate_eff   = (cfg.sample_rate == '0) ? iadf_pkg::RATE_W'(1) : cfg.sample_rate;
   assign bits_chans = bits_eff * chans_eff;

   always_comb begin
      unique case (cmd.div_sel)
         iadf_pkg::DIV_FRAMES: begin
            div_dividend = iadf_pkg::DIV_W'({left_ff, 3'b000});
            div_divisor  = iadf_pkg::DVR_W'(bits_chans);
         end
         iadf_pkg::DIV_STAMP: begin
            div_dividend = product_ff;
            div_divisor  = rate_eff;
         end
         // stamp / 90000 equals total / rate while the stamp is not saturated
         iadf_pkg::DIV_SECONDS: begin
            div_dividend = iadf_pkg::DIV_W'(total_ff);
            div_divisor  = rate_eff;
         end
         default: begin
            div_dividend = iadf_pkg::DIV_W'({left_ff, 3'b000});
            div_divisor  = iadf_pkg::DVR_W'(bits_chans);
         end
      endcase
   end

   iadf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign total_sum = {1'b0, total_ff} + {1'b0, quotient[iadf_pkg::TOTAL_W-1:0]};
   assign product   = total_ff * iadf_pkg::TICKS_PER_SEC;

   always_comb begin
      total_in = total_ff;
      stamp_in = stamp_ff;
      if (cmd.total_load) begin
         total_in = total_sum[iadf_pkg::TOTAL_W] ? '1 : total_sum[iadf_pkg::TOTAL_W-1:0];
      end
      if (cmd.stamp_load) begin
         stamp_in = (quotient[iadf_pkg::DIV_W-1:iadf_pkg::STAMP_W] != '0) ? '1
                    : quotient[iadf_pkg::STAMP_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= (iadf_pkg::HEADER_BYTES == 0) ? iadf_pkg::PH_PREAMBLE
                                                       : iadf_pkg::PH_HEADER;
         count_ff     <= '0;
         left_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         stamp_ff     <= '0;
         seconds_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.seconds_load) begin
            seconds_ff <= (stamp_ff == '1) ? iadf_pkg::SECONDS_MAX
                                           : quotient[iadf_pkg::SEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      preamble_ff <= preamble_in;
      if (cmd.product_load) begin
         product_ff <= product;
      end
      if (out_load) begin
         rsp_byte_ff    <= req_stream_byte;
         rsp_stamp_ff   <= stamp_ff;
         rsp_seconds_ff <= seconds_ff;
         rsp_bend_ff    <= bend;
         rsp_cend_ff    <= cend;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_stamp         = rsp_stamp_ff;
   assign rsp_stamp_seconds = rsp_seconds_ff;
   assign rsp_buffer_end    = rsp_bend_ff;
   assign rsp_chunk_end     = rsp_cend_ff;

`ifndef SYNTHESIS
   // no byte may slip in while the divider is busy with the chunk arithmetic
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      accept |-> !div_busy)
      else $error("byte accepted while divider busy");

   // skip and payload phases always have bytes outstanding
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == iadf_pkg::PH_SKIP || phase_ff == iadf_pkg::PH_PAYLOAD) |-> left_ff != '0)
      else $error("skip or payload phase with no bytes left");

   // a result only appears after an accepted payload byte
   a_result_from_payload: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && phase_ff == iadf_pkg::PH_PAYLOAD))
      else $error("result without a payload byte");

   // the last byte of a chunk always closes the buffer
   a_chunk_end_closes_buffer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cend_ff) |-> rsp_bend_ff)
      else $error("chunk end without buffer end");
`endif

endmodule
